// ===== hdl/nlc_pkg.sv =====
// ----------------------------------------------------------------------------
// nlc_pkg
// Shared types for the numeric literal classifier: the class code that the
// scanner produces and the top level delivers.
// ----------------------------------------------------------------------------
package nlc_pkg;

    // Class of a finished token.
    typedef enum logic [2:0] {
        CLS_FLOAT   = 3'd0,
        CLS_DEC     = 3'd1,
        CLS_INVALID = 3'd2,
        CLS_HEX     = 3'd3,
        CLS_OCT     = 3'd4,
        CLS_BIN     = 3'd5
    } t_num_class;

endpackage

// ===== hdl/numeric_literal_classifier.sv =====
// ----------------------------------------------------------------------------
// numeric_literal_classifier
// Classifies a numeric literal that arrives one character per item.
// ----------------------------------------------------------------------------
// Usage: the input channel (i_in_valid / o_in_stall) carries one character of
// a token per item in i_char_code. i_no_char marks an item without a
// character, and a zero byte is treated the same way. The item with i_last
// set ends the token; it produces exactly one result on the output channel
// (o_out_valid / i_out_stall), the class of the whole token in
// o_number_class. Items without i_last produce no result.
// Timing: an accepted item is held in an input register; when it leaves, the
// scanner logic updates the scan phase and, for a last item, loads the result
// register. A result thus passes the input register and then the result
// register before it shows on o_out_valid. One item is accepted every cycle
// as long as the receiver keeps up; the only limit is the single result
// register on the output side.
// Stall: while a result waits in the result register, items that carry no
// result still flow through. A last item waits in the input register until
// the result register is free or is being emptied in the same cycle, and
// o_in_stall stays high for new items for as long as it waits.
// Reset: clears both registers' valid flags and returns the scan phase to
// the start of a token.
// ----------------------------------------------------------------------------
module numeric_literal_classifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_no_char,
    input  logic       i_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_number_class
);

    // Input register.
    logic       r_s1_valid;
    logic [7:0] r_s1_char;
    logic       r_s1_no_char;
    logic       r_s1_last;

    // Result register.
    logic                r_out_valid;
    nlc_pkg::t_num_class r_out_class;

    logic                w_s1_adv;
    logic                w_s1_fire;
    logic                w_in_fire;
    logic                w_out_take;
    nlc_pkg::t_num_class w_class;

    // The input register can move on unless it holds a last item and the
    // result register stays full this cycle.
    assign w_out_take = r_out_valid && !i_out_stall;
    assign w_s1_adv   = !r_s1_last || !r_out_valid || !i_out_stall;
    assign w_s1_fire  = r_s1_valid && w_s1_adv;
    assign o_in_stall = r_s1_valid && !w_s1_adv;
    assign w_in_fire  = i_in_valid && !o_in_stall;

    nlc_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_s1_fire),
        .i_char_code (r_s1_char),
        .i_no_char   (r_s1_no_char),
        .i_last      (r_s1_last),
        .o_class     (w_class)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_char    <= i_char_code;
            r_s1_no_char <= i_no_char;
            r_s1_last    <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_fire && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire && r_s1_last) begin
            r_out_class <= w_class;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_number_class = r_out_class;

`ifndef SYNTHESIS
    // The block only pushes back while it holds an item it cannot pass on.
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s1_last && r_out_valid))
        else $error("input stalled without a blocked last item");

    // A last item leaving the input register always shows up as a result.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_fire && r_s1_last) |=> o_out_valid)
        else $error("last item did not produce a result");

    // Delivered class codes stay within the defined set.
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_number_class <= 3'd5))
        else $error("undefined class code delivered");
`endif

endmodule

// ===== hdl/nlc_scan.sv =====
// ----------------------------------------------------------------------------
// nlc_scan
// Scan phase register and the per-character transition logic. On each step
// with a character the phase advances by it. A step ending the token returns
// the phase to the start, and the class of the token is presented on o_class.
// ----------------------------------------------------------------------------
module nlc_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_char_code,
    input  logic                  i_no_char,
    input  logic                  i_last,
    output nlc_pkg::t_num_class   o_class
);

    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_MINUS   = 4'd1,
        PH_ZERO    = 4'd2,
        PH_HEXPFX  = 4'd3,
        PH_OCTPFX  = 4'd4,
        PH_BINPFX  = 4'd5,
        PH_HEX     = 4'd6,
        PH_OCT     = 4'd7,
        PH_BIN     = 4'd8,
        PH_DEC     = 4'd9,
        PH_FLOAT   = 4'd10,
        PH_INVALID = 4'd11
    } t_phase;

    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_ONE   = 8'h31;
    localparam logic [7:0] C_SEVEN = 8'h37;
    localparam logic [7:0] C_EIGHT = 8'h38;
    localparam logic [7:0] C_NINE  = 8'h39;
    localparam logic [7:0] C_UP_A  = 8'h41;
    localparam logic [7:0] C_UP_B  = 8'h42;
    localparam logic [7:0] C_UP_F  = 8'h46;
    localparam logic [7:0] C_UP_O  = 8'h4F;
    localparam logic [7:0] C_UP_X  = 8'h58;
    localparam logic [7:0] C_LO_A  = 8'h61;
    localparam logic [7:0] C_LO_B  = 8'h62;
    localparam logic [7:0] C_LO_F  = 8'h66;
    localparam logic [7:0] C_LO_O  = 8'h6F;
    localparam logic [7:0] C_LO_X  = 8'h78;

    t_phase r_phase;
    t_phase n_phase;
    t_phase w_scan;
    logic   w_has_char;

    function automatic t_phase dec_rule(input logic [7:0] c);
        t_phase p;
        if (c == C_DOT) begin
            p = PH_FLOAT;
        end else if (c inside {[C_ZERO:C_NINE]}) begin
            p = PH_DEC;
        end else begin
            p = PH_INVALID;
        end
        return p;
    endfunction

    function automatic t_phase oct_rule(input logic [7:0] c);
        t_phase p;
        if (c inside {[C_ZERO:C_SEVEN]}) begin
            p = PH_OCT;
        end else if (c == C_EIGHT || c == C_NINE) begin
            p = PH_DEC;
        end else if (c == C_DOT) begin
            p = PH_FLOAT;
        end else begin
            p = PH_INVALID;
        end
        return p;
    endfunction

    // A zero byte counts as no character.
    assign w_has_char = !i_no_char && (i_char_code != 8'h00);

    always_comb begin
        w_scan = r_phase;
        if (w_has_char) begin
            case (r_phase)
                PH_START: begin
                    if (i_char_code == C_MINUS) begin
                        w_scan = PH_MINUS;
                    end else if (i_char_code == C_ZERO) begin
                        w_scan = PH_ZERO;
                    end else begin
                        w_scan = dec_rule(i_char_code);
                    end
                end
                PH_MINUS: begin
                    if (i_char_code == C_ZERO) begin
                        w_scan = PH_ZERO;
                    end else begin
                        w_scan = dec_rule(i_char_code);
                    end
                end
                PH_ZERO: begin
                    if (i_char_code == C_LO_X || i_char_code == C_UP_X) begin
                        w_scan = PH_HEXPFX;
                    end else if (i_char_code == C_LO_O || i_char_code == C_UP_O) begin
                        w_scan = PH_OCTPFX;
                    end else if (i_char_code == C_LO_B || i_char_code == C_UP_B) begin
                        w_scan = PH_BINPFX;
                    end else begin
                        w_scan = oct_rule(i_char_code);
                    end
                end
                PH_HEXPFX, PH_HEX: begin
                    if (i_char_code inside {[C_ZERO:C_NINE], [C_LO_A:C_LO_F],
                                            [C_UP_A:C_UP_F]}) begin
                        w_scan = PH_HEX;
                    end else begin
                        w_scan = PH_INVALID;
                    end
                end
                PH_OCTPFX, PH_OCT: begin
                    w_scan = oct_rule(i_char_code);
                end
                PH_BINPFX, PH_BIN: begin
                    if (i_char_code == C_ZERO || i_char_code == C_ONE) begin
                        w_scan = PH_BIN;
                    end else begin
                        w_scan = PH_INVALID;
                    end
                end
                PH_DEC: begin
                    w_scan = dec_rule(i_char_code);
                end
                PH_FLOAT: begin
                    if (i_char_code inside {[C_ZERO:C_NINE]}) begin
                        w_scan = PH_FLOAT;
                    end else begin
                        w_scan = PH_INVALID;
                    end
                end
                default: begin
                    w_scan = PH_INVALID;
                end
            endcase
        end
    end

    always_comb begin
        case (w_scan)
            PH_ZERO:  o_class = nlc_pkg::CLS_DEC;
            PH_HEX:   o_class = nlc_pkg::CLS_HEX;
            PH_OCT:   o_class = nlc_pkg::CLS_OCT;
            PH_BIN:   o_class = nlc_pkg::CLS_BIN;
            PH_DEC:   o_class = nlc_pkg::CLS_DEC;
            PH_FLOAT: o_class = nlc_pkg::CLS_FLOAT;
            default:  o_class = nlc_pkg::CLS_INVALID;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            n_phase = i_last ? PH_START : w_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule
